// File: rtl/camera_tracking_packet_parser_macros.svh
// Assertion macros used by the camera tracking packet parser checker.
`ifndef CAMERA_TRACKING_PACKET_PARSER_MACROS_SVH
`define CAMERA_TRACKING_PACKET_PARSER_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define CTPP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define CTPP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ctpp_pkg.sv
// Types and constants of the camera tracking packet parser.
`default_nettype none

package ctpp_pkg;

   localparam int FRAME_LENGTH = 29;
   localparam int SUM_LAST     = 28;
   localparam logic [7:0] CHECK_SEED    = 8'h40;
   localparam logic [7:0] MARKER_RESET  = 8'd209;
   localparam int COUNT_W      = 5;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LENS_BIAS     = 4'd0,
      CSR_PACKET_MARKER = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_TOO_SHORT    = 2'd1,
      STATUS_BAD_MARKER   = 2'd2,
      STATUS_BAD_CHECKSUM = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_datagram;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         camera_code;
      logic signed [23:0] pitch_raw;
      logic signed [23:0] yaw_raw;
      logic signed [23:0] roll_raw;
      logic signed [23:0] pos_z_raw;
      logic signed [23:0] pos_y_raw;
      logic signed [23:0] pos_x_raw;
      logic [15:0]        zoom_value;
      logic [15:0]        focus_value;
   } rsp_payload_type;

   // Raw lens value minus offset, zero when at or below the offset.
   function automatic logic [15:0] lens_value(input logic [23:0] raw,
                                              input logic [23:0] offset);
      logic [23:0] diff;
      diff = raw - offset;
      if (raw <= offset) begin
         return 16'd0;
      end
      return diff[15:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/camera_tracking_packet_parser.sv
// Top level of the camera tracking packet parser.
// One datagram byte is taken per transfer on req_ and the byte flagged with
// end_of_datagram yields one result on rsp_; bytes without the flag yield
// nothing. The block takes a byte in every cycle with req_stall low: the byte
// counter, the running mod-256 checksum and the 29 byte holding registers all
// update in the cycle of the transfer, and the result is formed from those
// registers plus the incoming byte by one level of compare and subtract logic
// in front of the result register. The result register is backed by a one-entry
// skid register, so req_stall rises only when two results wait on a stalled rsp_
// side. Bytes beyond the 29th are dropped. Status is checked as too short, bad
// marker, bad checksum, ok; on any failure every field but status is zero.
// Zoom and focus are the unsigned 24-bit values minus the lens bias register,
// clamped at zero and cut to 16 bits. Register writes on csr_ are taken in any
// cycle (csr_ready is always high) and act from the next byte on.
`default_nettype none

module camera_tracking_packet_parser
   import ctpp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // byte channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_payload,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_payload,
   // register write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [23:0] lens_bias_ff;
   logic [7:0]  packet_marker_ff;

   // datagram state
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]         running_sum_ff, running_sum_in;
   logic [7:0]         packet_bytes_ff [FRAME_LENGTH];

   // result register and skid register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff, skid_data_in;

   logic            req_transfer;
   logic            store_byte;
   logic            add_to_sum;
   logic            frame_full;
   logic [7:0]      sum_next;
   logic [7:0]      check_byte;
   logic [7:0]      expected_check;
   logic            new_result;
   logic            out_free;
   rsp_payload_type result;

   assign csr_ready    = 1'b1;
   assign req_stall    = skid_valid_ff;
   assign req_transfer = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_data_ff;

   // Register writes; indexes outside the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         lens_bias_ff     <= '0;
         packet_marker_ff <= MARKER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LENS_BIAS:     lens_bias_ff     <= csr_wdata[23:0];
            CSR_PACKET_MARKER: packet_marker_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Keep only the first FRAME_LENGTH bytes; only bytes 0..27 enter the sum.
   assign store_byte = byte_count_ff < COUNT_W'(FRAME_LENGTH);
   assign add_to_sum = byte_count_ff < COUNT_W'(SUM_LAST);
   assign sum_next   = add_to_sum ? running_sum_ff + req_payload.rx_byte : running_sum_ff;

   always_comb begin
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      if (req_transfer) begin
         if (req_payload.end_of_datagram) begin
            byte_count_in  = '0;
            running_sum_in = '0;
         end else begin
            running_sum_in = sum_next;
            if (store_byte) begin
               byte_count_in = byte_count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         running_sum_ff <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer && store_byte) begin
         packet_bytes_ff[byte_count_ff] <= req_payload.rx_byte;
      end
   end

   // The frame is complete once byte 28 is in hand, either stored earlier or
   // arriving now. A complete frame means bytes 0..27 are already stored, so
   // only the checksum byte may come from the input.
   assign frame_full     = byte_count_ff >= COUNT_W'(FRAME_LENGTH - 1);
   assign check_byte     = (byte_count_ff == COUNT_W'(SUM_LAST)) ?
                           req_payload.rx_byte : packet_bytes_ff[SUM_LAST];
   assign expected_check = CHECK_SEED - sum_next;

   always_comb begin
      result = '0;
      if (!frame_full) begin
         result.status = STATUS_TOO_SHORT;
      end else if (packet_bytes_ff[0] != packet_marker_ff) begin
         result.status = STATUS_BAD_MARKER;
      end else if (expected_check != check_byte) begin
         result.status = STATUS_BAD_CHECKSUM;
      end else begin
         result.status      = STATUS_OK;
         result.camera_code = packet_bytes_ff[1];
         result.pitch_raw   = {packet_bytes_ff[2],  packet_bytes_ff[3],  packet_bytes_ff[4]};
         result.yaw_raw     = {packet_bytes_ff[5],  packet_bytes_ff[6],  packet_bytes_ff[7]};
         result.roll_raw    = {packet_bytes_ff[8],  packet_bytes_ff[9],  packet_bytes_ff[10]};
         result.pos_z_raw   = {packet_bytes_ff[11], packet_bytes_ff[12], packet_bytes_ff[13]};
         result.pos_y_raw   = {packet_bytes_ff[14], packet_bytes_ff[15], packet_bytes_ff[16]};
         result.pos_x_raw   = {packet_bytes_ff[17], packet_bytes_ff[18], packet_bytes_ff[19]};
         result.zoom_value  = lens_value({packet_bytes_ff[20], packet_bytes_ff[21],
                                          packet_bytes_ff[22]}, lens_bias_ff);
         result.focus_value = lens_value({packet_bytes_ff[23], packet_bytes_ff[24],
                                          packet_bytes_ff[25]}, lens_bias_ff);
      end
   end

   // Output register with skid: a new result goes to the output register when
   // it frees up, else into the skid register; the skid drains first.
   assign new_result = req_transfer && req_payload.end_of_datagram;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = new_result;
            rsp_data_in  = result;
         end
      end else if (new_result) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

// File: rtl/ctpp_checker.sv
// Port-level checks of the camera tracking packet parser and their binding.
`default_nettype none

`include "camera_tracking_packet_parser_macros.svh"

module ctpp_checker
   import ctpp_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire rsp_payload_type        rsp_payload
);

   // A stalled result holds.
   `CTPP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled result changed")

   // Reset empties the result side.
   `CTPP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "result pending after reset")

   // Backpressure reaches the byte side only while a result waits.
   `CTPP_ASSERT(a_stall_needs_result, clock, reset, req_stall |-> rsp_valid, "byte side stalled with no result waiting")

   // A failed packet carries nothing but its status.
   `CTPP_ASSERT(a_fail_zero, clock, reset, rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.camera_code == 8'd0 && rsp_payload.pitch_raw == 24'sd0 && rsp_payload.pos_x_raw == 24'sd0 && rsp_payload.zoom_value == 16'd0 && rsp_payload.focus_value == 16'd0, "failed packet carries data")

endmodule

bind camera_tracking_packet_parser ctpp_checker u_ctpp_checker (.*);

`default_nettype wire
